/* hdl/fjst_pkg.sv */
`default_nettype none

package fjst_pkg;

    typedef enum logic [3:0] {
        ST_BEGIN     = 4'd0,
        ST_EXPECT_ID = 4'd1,
        ST_ID        = 4'd2,
        ST_HAD_ID    = 4'd3,
        ST_VAL       = 4'd4,
        ST_STR       = 4'd5,
        ST_ESC       = 4'd6,
        ST_INT       = 4'd7,
        ST_NEG       = 4'd8,
        ST_FRAC      = 4'd9,
        ST_END_VAL   = 4'd10,
        ST_ERROR     = 4'd11
    } parse_state_t;

    typedef enum logic {
        CFG_ID_CAPACITY    = 1'b0,
        CFG_VALUE_CAPACITY = 1'b1
    } cfg_index_t;

    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;

    localparam logic [7:0] ID_CAPACITY_RESET    = 8'd20;
    localparam logic [7:0] VALUE_CAPACITY_RESET = 8'd100;

    localparam logic signed [8:0] NO_ARRAY  = -9'sd1;
    localparam logic signed [8:0] ARRAY_MAX = 9'sd255;

endpackage

`default_nettype wire

/* hdl/flat_json_stream_tokenizer_core.sv */
`default_nettype none

// Tokenizer for flat JSON objects, one received byte per input word. Each byte
// is decoded combinationally against the parser state and the result lands
// in an output register, so the block takes one byte every cycle as long as
// the output side keeps taking words; for every cycle an output word waits
// unaccepted, no new byte is taken. Every accepted byte yields exactly one output word
// carrying the append character, the array element index and the event flags. A newline
// byte always returns the parser to waiting for '{'. Capacity registers are written through
// the cfg port; the user must do so only while the block is idle, it is not enforced.
module flat_json_stream_tokenizer_core
    import fjst_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_wdata,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [7:0] out_char, [16:8] array_index, zero fill
    output logic [5:0]       m_axis_tuser,   // msg_start, id_start, id_char_valid,
                                             // val_char_valid, field_done, parse_error
    output logic             m_axis_tlast    // msg_end
);

    logic [7:0]        id_capacity_reg;
    logic [7:0]        value_capacity_reg;

    parse_state_t      state_reg, state_next;
    logic signed [8:0] array_count_reg, array_count_next;
    logic [7:0]        id_length_reg, id_length_next;
    logic [7:0]        value_length_reg, value_length_next;

    logic              out_valid_reg;
    logic              msg_start_reg, id_start_reg, id_valid_reg, val_valid_reg;
    logic              field_done_reg, msg_end_reg, parse_error_reg;
    logic [7:0]        out_char_reg;
    logic signed [8:0] array_index_reg;

    logic              msg_start_next, id_start_next, id_valid_next, val_valid_next;
    logic              field_done_next, msg_end_next;
    logic [7:0]        out_char_next;
    logic signed [8:0] array_index_next;

    logic [7:0]        c;
    logic              in_accept;
    logic              is_digit;
    logic              in_array;
    logic              val_room;

    assign c             = s_axis_tdata;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign is_digit      = (c >= CH_ZERO) && (c <= CH_NINE);
    assign in_array      = !array_count_reg[8];
    assign val_room      = value_length_reg < value_capacity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_capacity_reg    <= ID_CAPACITY_RESET;
            value_capacity_reg <= VALUE_CAPACITY_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ID_CAPACITY:    id_capacity_reg    <= cfg_wdata;
                CFG_VALUE_CAPACITY: value_capacity_reg <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        array_count_next  = array_count_reg;
        id_length_next    = id_length_reg;
        value_length_next = value_length_reg;
        msg_start_next    = 1'b0;
        id_start_next     = 1'b0;
        id_valid_next     = 1'b0;
        val_valid_next    = 1'b0;
        out_char_next     = 8'd0;
        field_done_next   = 1'b0;
        array_index_next  = 9'sd0;
        msg_end_next      = 1'b0;

        if (c == CH_NEWLINE)
        begin
            state_next = ST_BEGIN;
        end
        else
        begin
            case (state_reg)
                ST_BEGIN:
                begin
                    if (c == CH_LBRACE)
                    begin
                        msg_start_next    = 1'b1;
                        value_length_next = 8'd0;
                        state_next        = ST_EXPECT_ID;
                    end
                end
                ST_EXPECT_ID:
                begin
                    if (c == CH_SPACE)
                    begin
                    end
                    else if (c == CH_QUOTE)
                    begin
                        id_start_next  = 1'b1;
                        id_length_next = 8'd0;
                        state_next     = ST_ID;
                    end
                    else if (c == CH_RBRACE)
                    begin
                        msg_end_next = 1'b1;
                        state_next   = ST_BEGIN;
                    end
                    else
                    begin
                        state_next = ST_ERROR;
                    end
                end
                ST_ID:
                begin
                    if (c == CH_QUOTE)
                    begin
                        state_next = ST_HAD_ID;
                    end
                    else if (c >= CH_SPACE && id_length_reg < id_capacity_reg)
                    begin
                        id_length_next = id_length_reg + 8'd1;
                        id_valid_next  = 1'b1;
                        out_char_next  = c;
                    end
                    else
                    begin
                        state_next = ST_ERROR;
                    end
                end
                ST_HAD_ID:
                begin
                    if (c == CH_COLON)
                    begin
                        array_count_next = NO_ARRAY;
                        state_next       = ST_VAL;
                    end
                    else if (c != CH_SPACE)
                    begin
                        state_next = ST_ERROR;
                    end
                end
                ST_VAL:
                begin
                    if (c == CH_SPACE)
                    begin
                    end
                    else if (c == CH_QUOTE)
                    begin
                        state_next = ST_STR;
                    end
                    else if (c == CH_LBRACKET)
                    begin
                        if (array_count_reg == NO_ARRAY)
                            array_count_next = 9'sd0;
                        else
                            state_next = ST_ERROR;
                    end
                    else if (c == CH_MINUS || is_digit)
                    begin
                        if (val_room)
                        begin
                            value_length_next = value_length_reg + 8'd1;
                            val_valid_next    = 1'b1;
                            out_char_next     = c;
                        end
                        state_next = (c == CH_MINUS) ? ST_NEG : ST_INT;
                    end
                    else
                    begin
                        state_next = ST_ERROR;
                    end
                end
                ST_STR:
                begin
                    if (c == CH_QUOTE)
                    begin
                        field_done_next   = 1'b1;
                        array_index_next  = array_count_reg;
                        value_length_next = 8'd0;
                        state_next        = ST_END_VAL;
                    end
                    else if (c == CH_BACKSLASH)
                    begin
                        state_next = ST_ESC;
                    end
                    else if (c < CH_SPACE)
                    begin
                        state_next = ST_ERROR;
                    end
                    else if (val_room)
                    begin
                        value_length_next = value_length_reg + 8'd1;
                        val_valid_next    = 1'b1;
                        out_char_next     = c;
                    end
                end
                ST_ESC:
                begin
                    // quote and backslash pass through, \n and \t become a space
                    if (val_room)
                    begin
                        if (c == CH_QUOTE || c == CH_BACKSLASH)
                        begin
                            value_length_next = value_length_reg + 8'd1;
                            val_valid_next    = 1'b1;
                            out_char_next     = c;
                        end
                        else if (c == CH_LOWER_N || c == CH_LOWER_T)
                        begin
                            value_length_next = value_length_reg + 8'd1;
                            val_valid_next    = 1'b1;
                            out_char_next     = CH_SPACE;
                        end
                    end
                    state_next = ST_STR;
                end
                ST_NEG:
                begin
                    if (is_digit)
                    begin
                        if (val_room)
                        begin
                            value_length_next = value_length_reg + 8'd1;
                            val_valid_next    = 1'b1;
                            out_char_next     = c;
                        end
                        state_next = ST_INT;
                    end
                    else
                    begin
                        state_next = ST_ERROR;
                    end
                end
                ST_INT, ST_FRAC:
                begin
                    if (state_reg == ST_INT && c == CH_DOT)
                    begin
                        if (val_room)
                        begin
                            value_length_next = value_length_reg + 8'd1;
                            val_valid_next    = 1'b1;
                            out_char_next     = c;
                        end
                        state_next = ST_FRAC;
                    end
                    else if (c == CH_COMMA)
                    begin
                        field_done_next   = 1'b1;
                        array_index_next  = array_count_reg;
                        value_length_next = 8'd0;
                        if (in_array)
                        begin
                            if (array_count_reg < ARRAY_MAX)
                                array_count_next = array_count_reg + 9'sd1;
                            state_next = ST_VAL;
                        end
                        else
                        begin
                            state_next = ST_EXPECT_ID;
                        end
                    end
                    else if (c == CH_RBRACKET)
                    begin
                        if (in_array)
                        begin
                            field_done_next   = 1'b1;
                            array_index_next  = array_count_reg;
                            value_length_next = 8'd0;
                            array_count_next  = NO_ARRAY;
                            state_next        = ST_END_VAL;
                        end
                        else
                        begin
                            state_next = ST_ERROR;
                        end
                    end
                    else if (c == CH_RBRACE)
                    begin
                        if (array_count_reg == NO_ARRAY)
                        begin
                            field_done_next   = 1'b1;
                            array_index_next  = array_count_reg;
                            value_length_next = 8'd0;
                            msg_end_next      = 1'b1;
                            state_next        = ST_BEGIN;
                        end
                        else
                        begin
                            state_next = ST_ERROR;
                        end
                    end
                    else if (is_digit)
                    begin
                        if (val_room)
                        begin
                            value_length_next = value_length_reg + 8'd1;
                            val_valid_next    = 1'b1;
                            out_char_next     = c;
                        end
                    end
                    else
                    begin
                        state_next = ST_ERROR;
                    end
                end
                ST_END_VAL:
                begin
                    // stray bytes after a closed value are ignored
                    if (c == CH_COMMA)
                    begin
                        if (in_array)
                        begin
                            if (array_count_reg < ARRAY_MAX)
                                array_count_next = array_count_reg + 9'sd1;
                            state_next = ST_VAL;
                        end
                        else
                        begin
                            state_next = ST_EXPECT_ID;
                        end
                    end
                    else if (c == CH_RBRACKET)
                    begin
                        if (in_array)
                            array_count_next = NO_ARRAY;
                        else
                            state_next = ST_ERROR;
                    end
                    else if (c == CH_RBRACE)
                    begin
                        if (array_count_reg == NO_ARRAY)
                        begin
                            msg_end_next = 1'b1;
                            state_next   = ST_BEGIN;
                        end
                        else
                        begin
                            state_next = ST_ERROR;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_BEGIN;
            array_count_reg  <= NO_ARRAY;
            id_length_reg    <= 8'd0;
            value_length_reg <= 8'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                state_reg        <= state_next;
                array_count_reg  <= array_count_next;
                id_length_reg    <= id_length_next;
                value_length_reg <= value_length_next;
                out_valid_reg    <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            msg_start_reg   <= msg_start_next;
            id_start_reg    <= id_start_next;
            id_valid_reg    <= id_valid_next;
            val_valid_reg   <= val_valid_next;
            out_char_reg    <= out_char_next;
            field_done_reg  <= field_done_next;
            array_index_reg <= array_index_next;
            msg_end_reg     <= msg_end_next;
            parse_error_reg <= (state_next == ST_ERROR);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, array_index_reg, out_char_reg};
    assign m_axis_tuser  = {parse_error_reg, field_done_reg, val_valid_reg,
                            id_valid_reg, id_start_reg, msg_start_reg};
    assign m_axis_tlast  = msg_end_reg;

`ifndef ASSERT_OFF
    // one append target per word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(id_valid_reg && val_valid_reg))
        else $error("identifier and value append in the same word");

    // a character is only carried with an append flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !id_valid_reg && !val_valid_reg) |-> (out_char_reg == 8'd0))
        else $error("out_char set without an append flag");

    // landing in the error state raises no events
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && parse_error_reg) |->
            !(msg_start_reg || id_start_reg || id_valid_reg || val_valid_reg
              || field_done_reg || msg_end_reg))
        else $error("event flag raised together with parse error");

    // a field completion always clears the value length
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && field_done_next) |=> (value_length_reg == 8'd0))
        else $error("value length not cleared after field completion");

    // index is -1 or a non-negative count only
    assert property (@(posedge clk) disable iff (!rst_n)
        array_count_reg[8] |-> (array_count_reg == NO_ARRAY))
        else $error("array count below minus one");
`endif

endmodule

`default_nettype wire
